FILE: rtl/qkd_pkg.sv
// qkd_pkg: types and constants shared by the quadrature knob decoder modules
// no dependencies

package qkd_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_START_VALUE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_LIMIT     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HIGH_LIMIT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_PHASE = 3'd3;

  // register reset values
  localparam logic signed [7:0] START_VALUE_RST   = 8'sd0;
  localparam logic signed [7:0] LOW_LIMIT_RST     = 8'sd0;
  localparam logic signed [7:0] HIGH_LIMIT_RST    = 8'sd8;
  localparam logic [1:0]        INITIAL_PHASE_RST = 2'b11;

  // phase codes, b in bit 1 and a in bit 0
  localparam logic [1:0] PH_00 = 2'b00;
  localparam logic [1:0] PH_01 = 2'b01;
  localparam logic [1:0] PH_10 = 2'b10;
  localparam logic [1:0] PH_11 = 2'b11;
  localparam logic [1:0] PH_BOTH = 2'b11;  // xor pattern of a double-bit jump

  // direction codes, two's complement of the step
  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  typedef struct packed {
    logic signed [7:0] start_value;
    logic signed [7:0] low_limit;
    logic signed [7:0] high_limit;
    logic [1:0]        initial_phase;
  } qkd_cfg_t;

  typedef struct packed {
    logic load_count;
    logic load_phase;
  } qkd_load_t;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic switch_level;
    logic take_press;
  } qkd_sample_t;

  typedef struct packed {
    logic [1:0]        last_phase;
    logic [1:0]        last_step;
    logic signed [7:0] knob_count;
    logic              switch_was_down;
    logic              press_pending;
  } qkd_state_t;

  typedef struct packed {
    logic signed [7:0] count;
    logic              press_seen;
  } qkd_result_t;

endpackage

FILE: rtl/qkd_cfg_regs.sv
// qkd_cfg_regs: configuration registers of the knob decoder and load strobes
// depends on qkd_pkg

module qkd_cfg_regs import qkd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [7:0]         wr_data_i,
  output qkd_cfg_t           cfg_o,
  output qkd_load_t          load_o
);

  qkd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d             = cfg_q;
    load_o.load_count = 1'b0;
    load_o.load_phase = 1'b0;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_START_VALUE: begin
          cfg_d.start_value = wr_data_i;
          load_o.load_count = 1'b1;
        end
        REG_LOW_LIMIT:  cfg_d.low_limit  = wr_data_i;
        REG_HIGH_LIMIT: cfg_d.high_limit = wr_data_i;
        REG_INITIAL_PHASE: begin
          cfg_d.initial_phase = wr_data_i[1:0];
          load_o.load_phase   = 1'b1;
        end
        default: ;  // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_value   <= START_VALUE_RST;
      cfg_q.low_limit     <= LOW_LIMIT_RST;
      cfg_q.high_limit    <= HIGH_LIMIT_RST;
      cfg_q.initial_phase <= INITIAL_PHASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/qkd_step.sv
// qkd_step: combinational update of the knob state for one sample
// depends on qkd_pkg

module qkd_step import qkd_pkg::*; (
  input  qkd_sample_t smp_i,
  input  qkd_state_t  st_i,
  input  qkd_cfg_t    cfg_i,
  output qkd_state_t  st_o,
  output qkd_result_t res_o
);

  logic [1:0]        phase;
  logic [1:0]        diff;
  logic [1:0]        change;
  logic signed [8:0] sum;
  logic signed [8:0] hi;
  logic signed [8:0] lo;
  logic signed [8:0] clamped;
  logic              down;
  logic              pending;

  assign phase = {smp_i.enc_b, smp_i.enc_a};
  assign diff  = phase ^ st_i.last_phase;

  always_comb begin
    st_o   = st_i;
    change = STEP_NONE;
    if (diff != PH_00) begin
      if (diff == PH_BOTH) begin
        change = st_i.last_step;  // jump repeats the last direction
      end else if ((st_i.last_phase == PH_00 && phase == PH_01) ||
                   (st_i.last_phase == PH_11 && phase == PH_10)) begin
        change         = STEP_UP;
        st_o.last_step = STEP_UP;
      end else if ((st_i.last_phase == PH_01 && phase == PH_00) ||
                   (st_i.last_phase == PH_10 && phase == PH_11)) begin
        change         = STEP_DOWN;
        st_o.last_step = STEP_DOWN;
      end
      st_o.last_phase = phase;
    end
    if (change == STEP_UP || change == STEP_DOWN) begin
      st_o.knob_count = clamped[7:0];
    end
    st_o.switch_was_down = down;
    st_o.press_pending   = pending & ~smp_i.take_press;
  end

  // wide sum, clamp to high first so the low limit wins when they cross
  assign sum = {st_i.knob_count[7], st_i.knob_count} + {{7{change[1]}}, change};
  assign hi  = {cfg_i.high_limit[7], cfg_i.high_limit};
  assign lo  = {cfg_i.low_limit[7], cfg_i.low_limit};

  always_comb begin
    clamped = sum;
    if (clamped > hi) clamped = hi;
    if (clamped < lo) clamped = lo;
  end

  assign down    = ~smp_i.switch_level;
  assign pending = st_i.press_pending | (down & ~st_i.switch_was_down);

  assign res_o.count      = st_o.knob_count;
  assign res_o.press_seen = pending;

endmodule

FILE: rtl/quadrature_knob_decoder_core.sv
// quadrature_knob_decoder_core: top level of the rotary knob decoder
// depends on qkd_pkg, qkd_cfg_regs and qkd_step

// Rotary knob decoder with push switch. Each input beat carries one sample of
// encoder lines a and b, the active-low switch level and a press acknowledge;
// each produces exactly one output beat with the saturated knob count and the
// sticky press flag. Quarter steps 00->01 and 11->10 count up, 01->00 and
// 10->11 count down, a double-bit jump repeats the last direction and other
// changes only track the phase. The count is clamped to [low_limit,
// high_limit], the low limit winning if the two cross. Throughput is one beat
// per clock unless the output stalls: a sample is captured in an input
// register and the state update is a single pass of small logic into the
// output register. The state update sits between those two registers, so a
// stalled output holds the one sample behind it. Write configuration only
// while no beat is in flight; writing start_value reloads the count and
// writing initial_phase reloads the stored phase.

module quadrature_knob_decoder_core import qkd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // enc_a, enc_b, switch_level, take_press, 4'b0
  // output stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [15:0]        m_axis_tdata_o,  // count[7:0], press_seen, 7'b0
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  qkd_cfg_t    cfg;
  qkd_load_t   load;
  qkd_sample_t in_q;
  logic        in_vld_q;
  qkd_state_t  st_q, st_d, st_next;
  qkd_result_t res, out_q;
  logic        out_vld_q;
  logic        in_acc;
  logic        advance;
  logic        out_free;
  logic        cfg_wr;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  qkd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_wr),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .load_o     (load)
  );

  // handshake: output slot frees when empty or taken this cycle
  assign out_free        = ~out_vld_q | m_axis_tready_i;
  assign advance         = in_vld_q & out_free;
  assign s_axis_tready_o = ~in_vld_q | out_free;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.enc_a        <= s_axis_tdata_i[0];
      in_q.enc_b        <= s_axis_tdata_i[1];
      in_q.switch_level <= s_axis_tdata_i[2];
      in_q.take_press   <= s_axis_tdata_i[3];
    end
  end

  // single-pass state update
  qkd_step u_step (
    .smp_i (in_q),
    .st_i  (st_q),
    .cfg_i (cfg),
    .st_o  (st_next),
    .res_o (res)
  );

  // knob state; config reloads must only happen while idle, a rule on the user that the block does not enforce
  always_comb begin
    st_d = st_q;
    priority if (advance) begin
      st_d = st_next;
    end else if (load.load_count || load.load_phase) begin
      if (load.load_count) st_d.knob_count = cfg_data_i;
      if (load.load_phase) st_d.last_phase = cfg_data_i[1:0];
    end else begin
      st_d = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.last_phase      <= INITIAL_PHASE_RST;
      st_q.last_step       <= STEP_NONE;
      st_q.knob_count      <= START_VALUE_RST;
      st_q.switch_was_down <= 1'b0;
      st_q.press_pending   <= 1'b0;
    end else begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_q.press_seen, out_q.count};

  // the count reported is the count kept
  a_count_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_q.count == st_q.knob_count))
    else $error("reported count differs from stored count");

  // an acknowledged press is cleared
  a_ack_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.take_press) |=> !st_q.press_pending)
    else $error("press flag not cleared by acknowledge");

  // only none, up or down are ever recorded
  a_step_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.last_step == STEP_NONE) || (st_q.last_step == STEP_UP) ||
    (st_q.last_step == STEP_DOWN))
    else $error("invalid direction code");

  // empty pipeline never blocks the input
  a_ready_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q && !out_vld_q) |-> s_axis_tready_o)
    else $error("input stalled with empty pipeline");

  // a start_value write while no sample advances reloads the count
  a_start_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_index_i == REG_START_VALUE && !advance) |=>
    (st_q.knob_count == $past(cfg_data_i)))
    else $error("count not reloaded by start_value write");

endmodule
